/* hw/rtl/sgbp_pkg.sv */
// sgbp_pkg: shared types and constants of the sliding Goertzel bin power block
// used by the controller, the datapath and the top level; depends on nothing

package sgbp_pkg;

  // fixed field and arithmetic widths
  localparam int CoefW    = 18;   // Q2.16 coefficient
  localparam int StateW   = 48;   // Q40.8 resonator state
  localparam int PowerW   = 63;   // integer bin power
  localparam int LimbW    = 24;   // multiplier operand width
  localparam int ProdW    = 2 * LimbW;
  localparam int ShiftW   = 7;    // partial product alignment
  localparam int AccW     = 128;  // signed Q.32 power accumulator
  localparam int PzW      = 4 * LimbW;  // |z1|*|z2|
  localparam int CzW      = 68;   // c*z1 at Q.24
  localparam int RndShift = 16;
  localparam int RndW     = CzW - RndShift;
  localparam int PwrFracW = 32;

  localparam logic signed [CoefW-1:0] CoefReset    = -18'sd101320;
  localparam logic [CoefW-1:0]        CoefMagReset = 18'd101320;

  // partial product selection for the shared multiplier
  typedef enum logic [4:0] {
    PP_NONE,
    PP_CZ_LO,
    PP_CZ_HI,
    PP_PZ_00,
    PP_PZ_01,
    PP_PZ_10,
    PP_PZ_11,
    PP_SQ1_00,
    PP_SQ1_01,
    PP_SQ1_11,
    PP_SQ2_00,
    PP_SQ2_01,
    PP_SQ2_11,
    PP_X0,
    PP_X1,
    PP_X2,
    PP_X3
  } pp_sel_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic    load_in;    // latch request, read delay line
    logic    comb;       // form comb output, write delay line
    logic    mul_valid;  // issue one partial product
    pp_sel_e pp_sel;
    logic    acc_clr;
    logic    z_upd;      // resonator step
    logic    mag_upd;    // refresh state magnitudes
    logic    pz_load;    // keep |z1|*|z2|
    logic    out_load;   // load result register
  } dp_cmd_t;

endpackage

/* hw/rtl/sgbp_ram.sv */
// sgbp_ram: generic single write port RAM with registered read
// no dependencies

module sgbp_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/sgbp_ctrl.sv */
// sgbp_ctrl: sequencer of the bin power block, steps the datapath through
// comb, resonator and power partial products; uses sgbp_pkg

module sgbp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sgbp_pkg::dp_cmd_t cmd_o
);

  import sgbp_pkg::*;

  localparam int StepW    = 4;
  localparam int CzSteps  = 2;
  localparam int PzSteps  = 4;
  localparam int PwrSteps = 10;

  typedef enum logic [3:0] {
    S_IDLE,
    S_COMB,
    S_CZ,
    S_CZ_DRAIN,
    S_ZUPD,
    S_MAG,
    S_PZ,
    S_PZ_DRAIN,
    S_PZ_LOAD,
    S_PWR,
    S_PWR_DRAIN,
    S_OUT
  } state_e;

  state_e           state_q;
  logic [StepW-1:0] step_q;
  logic             out_valid_q;
  logic             slot_free;
  dp_cmd_t          cmd;

  assign slot_free = !out_valid_q || out_ready_i;

  // command decode
  always_comb begin
    cmd        = '0;
    cmd.pp_sel = PP_NONE;
    unique case (state_q)
      S_IDLE: begin
        cmd.load_in = in_valid_i;
      end
      S_COMB: begin
        cmd.comb    = 1'b1;
        cmd.acc_clr = 1'b1;
      end
      S_CZ: begin
        cmd.mul_valid = 1'b1;
        cmd.pp_sel    = (step_q == '0) ? PP_CZ_LO : PP_CZ_HI;
      end
      S_ZUPD: begin
        cmd.z_upd   = 1'b1;
        cmd.acc_clr = 1'b1;
      end
      S_MAG: begin
        cmd.mag_upd = 1'b1;
      end
      S_PZ: begin
        cmd.mul_valid = 1'b1;
        unique case (step_q)
          4'd0:    cmd.pp_sel = PP_PZ_00;
          4'd1:    cmd.pp_sel = PP_PZ_01;
          4'd2:    cmd.pp_sel = PP_PZ_10;
          default: cmd.pp_sel = PP_PZ_11;
        endcase
      end
      S_PZ_LOAD: begin
        cmd.pz_load = 1'b1;
        cmd.acc_clr = 1'b1;
      end
      S_PWR: begin
        cmd.mul_valid = 1'b1;
        unique case (step_q)
          4'd0:    cmd.pp_sel = PP_SQ1_00;
          4'd1:    cmd.pp_sel = PP_SQ1_01;
          4'd2:    cmd.pp_sel = PP_SQ1_11;
          4'd3:    cmd.pp_sel = PP_SQ2_00;
          4'd4:    cmd.pp_sel = PP_SQ2_01;
          4'd5:    cmd.pp_sel = PP_SQ2_11;
          4'd6:    cmd.pp_sel = PP_X0;
          4'd7:    cmd.pp_sel = PP_X1;
          4'd8:    cmd.pp_sel = PP_X2;
          default: cmd.pp_sel = PP_X3;
        endcase
      end
      S_OUT: begin
        cmd.out_load = slot_free;
      end
      default: begin
        cmd.pp_sel = PP_NONE;
      end
    endcase
  end

  // state, step counter and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_COMB;
          end
        end
        S_COMB: begin
          state_q <= S_CZ;
          step_q  <= '0;
        end
        S_CZ: begin
          if (step_q == StepW'(CzSteps - 1)) begin
            state_q <= S_CZ_DRAIN;
            step_q  <= '0;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        S_CZ_DRAIN: state_q <= S_ZUPD;
        S_ZUPD:     state_q <= S_MAG;
        S_MAG: begin
          state_q <= S_PZ;
          step_q  <= '0;
        end
        S_PZ: begin
          if (step_q == StepW'(PzSteps - 1)) begin
            state_q <= S_PZ_DRAIN;
            step_q  <= '0;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        S_PZ_DRAIN: state_q <= S_PZ_LOAD;
        S_PZ_LOAD: begin
          state_q <= S_PWR;
          step_q  <= '0;
        end
        S_PWR: begin
          if (step_q == StepW'(PwrSteps - 1)) begin
            state_q <= S_PWR_DRAIN;
            step_q  <= '0;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        S_PWR_DRAIN: state_q <= S_OUT;
        S_OUT: begin
          if (slot_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  // an accepted request keeps the block busy for the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while sequence running");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  // a result only appears from the final step
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result valid raised outside output step");

endmodule

/* hw/rtl/sgbp_datapath.sv */
// sgbp_datapath: delay line, comb, resonator state, shared 24x24 multiplier
// and 128-bit accumulator; uses sgbp_pkg and sgbp_ram

module sgbp_datapath #(
  parameter int WINDOW      = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  sgbp_pkg::dp_cmd_t                     cmd_i,
  input  logic [SAMPLE_BITS-1:0]                sample_i,
  input  logic                                  first_sample_i,
  input  logic                                  cfg_we_i,
  input  logic [sgbp_pkg::CoefW-1:0]            cfg_wdata_i,
  output logic [sgbp_pkg::PowerW-1:0]           power_o
);

  import sgbp_pkg::*;

  localparam int AddrW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FillW  = $clog2(WINDOW + 1);
  localparam int DiffW  = SAMPLE_BITS + 1;
  localparam int CombW  = DiffW + 8;
  localparam int SumW   = ((CombW > RndW) ? CombW : RndW) + 2;

  // control state
  logic [FillW-1:0]  fill_q;
  logic [AddrW-1:0]  wr_q;
  logic [StateW-1:0] z1_q, z2_q;
  logic [StateW-1:0] m1_q, m2_q;
  logic [CoefW-1:0]  coef_q;
  logic [CoefW-1:0]  cmag_q;
  logic              term_valid_q;

  // payload
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [DiffW-1:0]       d_q;
  logic [ProdW-1:0]       prod_q;
  logic [ShiftW-1:0]      sh_q;
  logic                   neg_q;
  logic [AccW-1:0]        acc_q;
  logic [PzW-1:0]         pz_q;
  logic [PowerW-1:0]      power_q;

  logic [SAMPLE_BITS-1:0] rdata;
  logic [SAMPLE_BITS-1:0] old_w;
  logic                   fill_full;
  logic [LimbW-1:0]       op_a, op_b;
  logic [ShiftW-1:0]      sh_w;
  logic                   neg_w;
  logic [ProdW-1:0]       prod_w;
  logic [AccW-1:0]        term_w;
  logic [AccW-1:0]        acc_d;
  logic [CzW-1:0]         cz_sum;
  logic [RndW-1:0]        cz_rnd;
  logic [CombW-1:0]       d_scaled;
  logic [SumW-1:0]        sum_w;
  logic                   sum_ovf;
  logic [StateW-1:0]      z0_w;
  logic [PowerW-1:0]      pwr_w;
  logic                   x_sign;

  // delay line
  sgbp_ram #(
    .Width(SAMPLE_BITS),
    .Depth(WINDOW)
  ) u_delay (
    .clk_i  (clk_i),
    .we_i   (cmd_i.comb),
    .waddr_i(wr_q),
    .wdata_i(sample_q),
    .re_i   (cmd_i.load_in),
    .raddr_i(wr_q),
    .rdata_o(rdata)
  );

  // comb: earlier sample counts only once the window has filled
  assign fill_full = (fill_q == FillW'(WINDOW));
  assign old_w     = fill_full ? rdata : '0;

  // partial product select
  assign x_sign = coef_q[CoefW-1] ^ z1_q[StateW-1] ^ z2_q[StateW-1];

  always_comb begin
    op_a  = '0;
    op_b  = '0;
    sh_w  = '0;
    neg_w = 1'b0;
    case (cmd_i.pp_sel)
      PP_CZ_LO: begin
        op_a  = LimbW'(cmag_q);
        op_b  = m1_q[LimbW-1:0];
        neg_w = coef_q[CoefW-1] ^ z1_q[StateW-1];
      end
      PP_CZ_HI: begin
        op_a  = LimbW'(cmag_q);
        op_b  = m1_q[StateW-1:LimbW];
        sh_w  = ShiftW'(24);
        neg_w = coef_q[CoefW-1] ^ z1_q[StateW-1];
      end
      PP_PZ_00: begin
        op_a = m1_q[LimbW-1:0];
        op_b = m2_q[LimbW-1:0];
      end
      PP_PZ_01: begin
        op_a = m1_q[LimbW-1:0];
        op_b = m2_q[StateW-1:LimbW];
        sh_w = ShiftW'(24);
      end
      PP_PZ_10: begin
        op_a = m1_q[StateW-1:LimbW];
        op_b = m2_q[LimbW-1:0];
        sh_w = ShiftW'(24);
      end
      PP_PZ_11: begin
        op_a = m1_q[StateW-1:LimbW];
        op_b = m2_q[StateW-1:LimbW];
        sh_w = ShiftW'(48);
      end
      // squares carry the extra 2^16 that aligns Q.16 to Q.32
      PP_SQ1_00: begin
        op_a = m1_q[LimbW-1:0];
        op_b = m1_q[LimbW-1:0];
        sh_w = ShiftW'(16);
      end
      PP_SQ1_01: begin
        op_a = m1_q[LimbW-1:0];
        op_b = m1_q[StateW-1:LimbW];
        sh_w = ShiftW'(41);
      end
      PP_SQ1_11: begin
        op_a = m1_q[StateW-1:LimbW];
        op_b = m1_q[StateW-1:LimbW];
        sh_w = ShiftW'(64);
      end
      PP_SQ2_00: begin
        op_a = m2_q[LimbW-1:0];
        op_b = m2_q[LimbW-1:0];
        sh_w = ShiftW'(16);
      end
      PP_SQ2_01: begin
        op_a = m2_q[LimbW-1:0];
        op_b = m2_q[StateW-1:LimbW];
        sh_w = ShiftW'(41);
      end
      PP_SQ2_11: begin
        op_a = m2_q[StateW-1:LimbW];
        op_b = m2_q[StateW-1:LimbW];
        sh_w = ShiftW'(64);
      end
      // cross term c*z1*z2 is subtracted
      PP_X0: begin
        op_a  = pz_q[LimbW-1:0];
        op_b  = LimbW'(cmag_q);
        neg_w = ~x_sign;
      end
      PP_X1: begin
        op_a  = pz_q[2*LimbW-1:LimbW];
        op_b  = LimbW'(cmag_q);
        sh_w  = ShiftW'(24);
        neg_w = ~x_sign;
      end
      PP_X2: begin
        op_a  = pz_q[3*LimbW-1:2*LimbW];
        op_b  = LimbW'(cmag_q);
        sh_w  = ShiftW'(48);
        neg_w = ~x_sign;
      end
      PP_X3: begin
        op_a  = pz_q[4*LimbW-1:3*LimbW];
        op_b  = LimbW'(cmag_q);
        sh_w  = ShiftW'(72);
        neg_w = ~x_sign;
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  assign prod_w = ProdW'(op_a) * ProdW'(op_b);

  // accumulate the registered product
  assign term_w = AccW'(prod_q) << sh_q;

  always_comb begin
    if (cmd_i.acc_clr) begin
      acc_d = '0;
    end else if (term_valid_q) begin
      acc_d = neg_q ? (acc_q - term_w) : (acc_q + term_w);
    end else begin
      acc_d = acc_q;
    end
  end

  // resonator step: d*256 + round(c*z1 / 2^16) - z2, saturated
  assign cz_sum   = acc_q[CzW-1:0] + CzW'(1 << (RndShift - 1));
  assign cz_rnd   = cz_sum[CzW-1:RndShift];
  assign d_scaled = {d_q, 8'b0};
  assign sum_w    = {{(SumW - CombW){d_scaled[CombW-1]}}, d_scaled}
                  + {{(SumW - RndW){cz_rnd[RndW-1]}}, cz_rnd}
                  - {{(SumW - StateW){z2_q[StateW-1]}}, z2_q};
  assign sum_ovf  = !((&sum_w[SumW-1:StateW-1]) || !(|sum_w[SumW-1:StateW-1]));

  always_comb begin
    if (!sum_ovf) begin
      z0_w = sum_w[StateW-1:0];
    end else if (sum_w[SumW-1]) begin
      z0_w = {1'b1, {(StateW - 1){1'b0}}};
    end else begin
      z0_w = {1'b0, {(StateW - 1){1'b1}}};
    end
  end

  // power: floor of Q.32 total, clipped at zero and saturated
  always_comb begin
    if (acc_q[AccW-1]) begin
      pwr_w = '0;
    end else if (|acc_q[AccW-1:PwrFracW+PowerW]) begin
      pwr_w = '1;
    end else begin
      pwr_w = acc_q[PwrFracW+PowerW-1:PwrFracW];
    end
  end

  // control state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= '0;
      wr_q         <= '0;
      z1_q         <= '0;
      z2_q         <= '0;
      m1_q         <= '0;
      m2_q         <= '0;
      coef_q       <= CoefReset;
      cmag_q       <= CoefMagReset;
      term_valid_q <= 1'b0;
    end else begin
      term_valid_q <= cmd_i.mul_valid;
      if (cfg_we_i) begin
        coef_q <= cfg_wdata_i;
        cmag_q <= cfg_wdata_i[CoefW-1] ? (~cfg_wdata_i + 1'b1) : cfg_wdata_i;
      end
      if (cmd_i.load_in && first_sample_i) begin
        fill_q <= '0;
        z1_q   <= '0;
        z2_q   <= '0;
        m1_q   <= '0;
        m2_q   <= '0;
      end
      if (cmd_i.comb) begin
        wr_q <= (wr_q == AddrW'(WINDOW - 1)) ? '0 : wr_q + 1'b1;
        if (!fill_full) begin
          fill_q <= fill_q + 1'b1;
        end
      end
      if (cmd_i.z_upd) begin
        z1_q <= z0_w;
        z2_q <= z1_q;
      end
      if (cmd_i.mag_upd) begin
        m1_q <= z1_q[StateW-1] ? (~z1_q + 1'b1) : z1_q;
        m2_q <= z2_q[StateW-1] ? (~z2_q + 1'b1) : z2_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      sample_q <= sample_i;
    end
    if (cmd_i.comb) begin
      d_q <= {sample_q[SAMPLE_BITS-1], sample_q} - {old_w[SAMPLE_BITS-1], old_w};
    end
    if (cmd_i.mul_valid) begin
      prod_q <= prod_w;
      sh_q   <= sh_w;
      neg_q  <= neg_w;
    end
    acc_q <= acc_d;
    if (cmd_i.pz_load) begin
      pz_q <= acc_q[PzW-1:0];
    end
    if (cmd_i.out_load) begin
      power_q <= pwr_w;
    end
  end

  assign power_o = power_q;

  // the multiplier pipeline is empty whenever the accumulator is consumed
  a_cz_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.z_upd |-> !term_valid_q)
    else $error("resonator step with product still in flight");

  a_pwr_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pz_load || cmd_i.out_load) |-> !term_valid_q)
    else $error("accumulator read with product still in flight");

  // fill count saturates at the window length
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.comb |=> (fill_q <= FillW'(WINDOW)))
    else $error("fill count beyond window");

endmodule

/* hw/rtl/sliding_goertzel_bin_power.sv */
// sliding_goertzel_bin_power: top level, joins sequencer and datapath
// uses sgbp_pkg, sgbp_ctrl, sgbp_datapath
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one request per sample:
//   sample_i and first_sample_i. first_sample_i high clears the resonator
//   and the window fill count before the sample, starting a new record.
//   Output channel (out_valid_o / out_ready_i) carries one power_o result
//   per request, in order.
//   The coefficient (2*cos of the bin angle, Q2.16) is written through
//   cfg_we_i / cfg_wdata_i; the user must write it only while the block is
//   idle, as the block itself does not enforce this. A request is accepted
//   only in the idle state, so a new one waits for the last sequence to end.
//   The single shared 24x24 multiplier works through 16 partial products
//   per sample (2 for the resonator feedback, 14 for the bin power).
//   Reset clears the resonator, the fill count and the delay line pointer and
//   loads the default coefficient; the delay line needs no clearing pass.
//   A stalled receiver holds the result in the output register; the next
//   request is still accepted and computed, and its sequence waits in the
//   last step until the output register is free.

module sliding_goertzel_bin_power #(
  parameter int WINDOW      = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [SAMPLE_BITS-1:0]       sample_i,
  input  logic                         first_sample_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [sgbp_pkg::PowerW-1:0]  power_o,
  input  logic                         cfg_we_i,
  input  logic [sgbp_pkg::CoefW-1:0]   cfg_wdata_i
);

  import sgbp_pkg::*;

  dp_cmd_t cmd;

  // sequencer
  sgbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd)
  );

  // arithmetic and storage
  sgbp_datapath #(
    .WINDOW     (WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sample_i      (sample_i),
    .first_sample_i(first_sample_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .power_o       (power_o)
  );

endmodule
